/* hw/rtl/info_frame_byte_stuffer_core_macros.svh */
// Assertion macros for the info frame byte stuffer.
// Used by the front, queue, back and top modules; expects i_clk and i_rst_n in scope.
`ifndef INFO_FRAME_BYTE_STUFFER_CORE_MACROS_SVH
`define INFO_FRAME_BYTE_STUFFER_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define IFBS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ifbs assertion failed");

// Antecedent implies consequent in the following cycle.
`define IFBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ifbs assertion failed");

`endif

/* hw/rtl/ifbs_pkg.sv */
// Shared types and byte codes for the info frame byte stuffer.
// No dependencies.
package ifbs_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLAG  = 8'h5E;
    localparam logic [7:0] ESC_ESC   = 8'h5D;
    localparam logic [7:0] CTRL_SEQ1 = 8'h40;
    localparam logic [7:0] CTRL_SEQ0 = 8'h00;
    localparam logic       CMD_DATA  = 1'b0;
    localparam logic       CMD_END   = 1'b1;

    // One classified item, handed from front to back.
    typedef struct packed {
        logic       hdr;     // emit frame header first
        logic [7:0] addr;
        logic [7:0] ctrl;
        logic [7:0] body;    // payload byte or check byte, before stuffing
        logic       is_end;  // closing flag follows the body
    } t_job;

    typedef enum logic [2:0] {
        PH_FLAG,
        PH_ADDR,
        PH_CTRL,
        PH_HCHK,
        PH_BODY,
        PH_ESC2,
        PH_CLOSE
    } t_phase;

endpackage

/* hw/rtl/ifbs_front.sv */
// Front end: accepts items, tracks frame state and the running check,
// and builds job descriptors. Depends on ifbs_pkg.
`include "info_frame_byte_stuffer_core_macros.svh"

module ifbs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_command,
    input  logic [7:0]        i_data_byte,
    input  logic              i_seq_bit,
    input  logic [7:0]        i_address,
    output ifbs_pkg::t_job    o_job
);

    logic       r_open;
    logic [7:0] r_check;
    logic       n_open;
    logic [7:0] n_check;
    logic [7:0] base_check;

    always_comb begin
        base_check   = r_open ? r_check : 8'h00;
        o_job.hdr    = !r_open;
        o_job.addr   = i_address;
        o_job.ctrl   = i_seq_bit ? ifbs_pkg::CTRL_SEQ1 : ifbs_pkg::CTRL_SEQ0;
        o_job.is_end = (i_command == ifbs_pkg::CMD_END);
        n_open       = r_open;
        n_check      = r_check;
        if (i_command == ifbs_pkg::CMD_DATA) begin
            o_job.body = i_data_byte;
            if (i_accept) begin
                n_open  = 1'b1;
                n_check = base_check ^ i_data_byte;
            end
        end else begin
            o_job.body = base_check;
            if (i_accept) begin
                n_open  = 1'b0;
                n_check = 8'h00;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_check <= 8'h00;
        end else begin
            r_open  <= n_open;
            r_check <= n_check;
        end
    end

    // Check is cleared whenever no frame is open.
    `IFBS_ASSERT_NOW(a_check_clear_idle, !r_open, r_check == 8'h00)

endmodule

/* hw/rtl/ifbs_queue.sv */
// Small job queue between front and back.
// Depends on ifbs_pkg.
`include "info_frame_byte_stuffer_core_macros.svh"

module ifbs_queue #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ifbs_pkg::t_job    i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output ifbs_pkg::t_job    o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ifbs_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Pop only with something stored, push only with room.
    `IFBS_ASSERT_NOW(a_pop_nonempty, i_pop, r_count != '0)
    `IFBS_ASSERT_NOW(a_push_room, i_push, r_count != CW'(DEPTH))

endmodule

/* hw/rtl/ifbs_back.sv */
// Back end: walks each job through header if set, stuffed body, closing flag if end,
// one byte a cycle into the output register unless stalled. Depends on ifbs_pkg.
`include "info_frame_byte_stuffer_core_macros.svh"

module ifbs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  ifbs_pkg::t_job    i_job,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_last_of_run,
    output logic              o_frame_done
);

    ifbs_pkg::t_phase r_phase;
    ifbs_pkg::t_phase n_phase;
    ifbs_pkg::t_phase cur;
    logic             r_valid;
    logic [7:0]       r_byte;
    logic             r_last;
    logic             r_done;
    logic             load;
    logic [7:0]       emit_byte;
    logic             emit_last;
    logic             emit_done;
    logic             body_esc;

    assign load     = i_job_valid && (!r_valid || !i_out_stall);
    assign body_esc = (i_job.body == ifbs_pkg::FLAG_BYTE) ||
                      (i_job.body == ifbs_pkg::ESC_BYTE);

    always_comb begin
        // Jobs without a header start straight at the body.
        cur = (r_phase == ifbs_pkg::PH_FLAG && !i_job.hdr) ? ifbs_pkg::PH_BODY : r_phase;
        emit_byte = ifbs_pkg::FLAG_BYTE;
        emit_last = 1'b0;
        emit_done = 1'b0;
        n_phase   = cur;
        case (cur)
            ifbs_pkg::PH_FLAG: begin
                emit_byte = ifbs_pkg::FLAG_BYTE;
                n_phase   = ifbs_pkg::PH_ADDR;
            end
            ifbs_pkg::PH_ADDR: begin
                emit_byte = i_job.addr;
                n_phase   = ifbs_pkg::PH_CTRL;
            end
            ifbs_pkg::PH_CTRL: begin
                emit_byte = i_job.ctrl;
                n_phase   = ifbs_pkg::PH_HCHK;
            end
            ifbs_pkg::PH_HCHK: begin
                emit_byte = i_job.addr ^ i_job.ctrl;
                n_phase   = ifbs_pkg::PH_BODY;
            end
            ifbs_pkg::PH_BODY: begin
                if (body_esc) begin
                    emit_byte = ifbs_pkg::ESC_BYTE;
                    n_phase   = ifbs_pkg::PH_ESC2;
                end else begin
                    emit_byte = i_job.body;
                    emit_last = !i_job.is_end;
                    n_phase   = i_job.is_end ? ifbs_pkg::PH_CLOSE : ifbs_pkg::PH_FLAG;
                end
            end
            ifbs_pkg::PH_ESC2: begin
                emit_byte = (i_job.body == ifbs_pkg::FLAG_BYTE) ? ifbs_pkg::ESC_FLAG
                                                                : ifbs_pkg::ESC_ESC;
                emit_last = !i_job.is_end;
                n_phase   = i_job.is_end ? ifbs_pkg::PH_CLOSE : ifbs_pkg::PH_FLAG;
            end
            ifbs_pkg::PH_CLOSE: begin
                emit_byte = ifbs_pkg::FLAG_BYTE;
                emit_last = 1'b1;
                emit_done = 1'b1;
                n_phase   = ifbs_pkg::PH_FLAG;
            end
            default: begin
                n_phase = ifbs_pkg::PH_FLAG;
            end
        endcase
        if (!load) begin
            n_phase = r_phase;
        end
    end

    assign o_pop = load && emit_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ifbs_pkg::PH_FLAG;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= emit_byte;
            r_last <= emit_last;
            r_done <= emit_done;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last;
    assign o_frame_done  = r_done;

    // Second half of an escape always follows the escape byte.
    `IFBS_ASSERT_NOW(a_esc_pair, r_phase == ifbs_pkg::PH_ESC2,
                     r_valid && r_byte == ifbs_pkg::ESC_BYTE)
    // Closing flag is the last byte of its item.
    `IFBS_ASSERT_NOW(a_done_is_last, r_valid && r_done,
                     r_last && r_byte == ifbs_pkg::FLAG_BYTE)

endmodule

/* hw/rtl/info_frame_byte_stuffer_core.sv */
// Top level of the info frame byte stuffer: front, job queue and back.
// Depends on ifbs_pkg, ifbs_front, ifbs_queue and ifbs_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one item per cycle unless
//   stalled: a payload byte (i_command = 0) or an end of frame (i_command = 1).
//   The first item of a frame also samples i_seq_bit for the control byte.
//   Output channel (o_out_valid / i_out_stall) gives one framed, stuffed byte
//   per cycle unless stalled; o_last_of_run marks the last byte an item
//   caused, o_frame_done the closing flag.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the address byte; it is
//   always ready and is meant to be written between frames.
// Timing:
//   First byte of an item passes through the job queue and then the output
//   register. The back end emits one byte a cycle while the output is not
//   stalled; an item makes 1 to 3 bytes inside a frame, up to 6 when a header
//   comes first. The front takes one item a cycle until the job queue
//   (QUEUE_DEPTH entries) fills; then o_in_stall rises.
// Reset and stall:
//   Reset closes any frame, clears the check, empties the queue and sets the
//   address to 3. A stall on the output holds the output byte; the queue keeps
//   taking items until full.
`include "info_frame_byte_stuffer_core_macros.svh"

module info_frame_byte_stuffer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input items
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_command,
    input  logic [7:0] i_data_byte,
    input  logic       i_seq_bit,
    // output items
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_frame_done,
    // address register write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic           r_address;
    logic [7:0]     r_addr_byte;
    logic           in_accept;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    ifbs_pkg::t_job front_job;
    ifbs_pkg::t_job head_job;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign in_accept   = i_in_valid && !q_full;

    // Address register; r_address flags that a write has been seen since reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_byte <= 8'h03;
            r_address   <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_addr_byte <= i_cfg_data;
            r_address   <= 1'b1;
        end
    end

    ifbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .i_seq_bit   (i_seq_bit),
        .i_address   (r_addr_byte),
        .o_job       (front_job)
    );

    ifbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    ifbs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_valid),
        .i_job         (head_job),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_frame_done  (o_frame_done)
    );

    // Address holds its reset value until the first write.
    `IFBS_ASSERT_NOW(a_addr_reset, !r_address, r_addr_byte == 8'h03)

endmodule
